FILE: sv/pbd_pkg.sv
// Shared types and constants for the pairwise beta dissimilarity block.
`timescale 1ns / 1ps

package pbd_pkg;

  localparam int ABUND_W  = 16;   // input abundance port width
  localparam int CNT_W    = 8;    // richness counters
  localparam int SUM_W    = 23;   // abundance sums
  localparam int TOT_W    = 24;   // sum of the two totals
  localparam int RSUM_W   = 9;    // sum of the two richness counts
  localparam int Q_W      = 17;   // Q1.16 dissimilarity
  localparam int QBITS    = 18;   // quotient bits, one per divider step
  localparam int STEP_W   = $clog2(QBITS);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [Q_W-1:0]   Q_ONE   = 17'd65536;

  // Accumulated statistics of one comparison.
  typedef struct packed {
    logic [CNT_W-1:0] rich_a;
    logic [CNT_W-1:0] rich_b;
    logic [CNT_W-1:0] shared;
    logic [SUM_W-1:0] min_sum;
    logic [SUM_W-1:0] tot_a;
    logic [SUM_W-1:0] tot_b;
  } acc_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

endpackage

FILE: sv/pbd_accum.sv
// Per-species accumulators: richness, shared count, minimum sum and totals.
`timescale 1ns / 1ps

module pbd_accum #(
  parameter int ABUND_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take_i,
  input  logic                              last_i,
  input  logic [pbd_pkg::ABUND_W-1:0]       abund_a_i,
  input  logic [pbd_pkg::ABUND_W-1:0]       abund_b_i,
  output pbd_pkg::acc_t                     acc_o
);

  localparam int AW = (ABUND_BITS < pbd_pkg::ABUND_W) ? ABUND_BITS : pbd_pkg::ABUND_W;
  localparam logic [pbd_pkg::ABUND_W-1:0] AMASK =
    pbd_pkg::ABUND_W'((33'd1 << AW) - 33'd1);

  pbd_pkg::acc_t acc_r, acc_nxt;

  logic [pbd_pkg::ABUND_W-1:0] a_m, b_m, min_ab;
  logic                        nz_a, nz_b;

  function automatic logic [pbd_pkg::CNT_W-1:0] cnt_inc(
    input logic [pbd_pkg::CNT_W-1:0] c
  );
    return (c == pbd_pkg::CNT_MAX) ? c : c + pbd_pkg::CNT_W'(1);
  endfunction

  function automatic logic [pbd_pkg::SUM_W-1:0] sum_add(
    input logic [pbd_pkg::SUM_W-1:0]   s,
    input logic [pbd_pkg::ABUND_W-1:0] v
  );
    logic [pbd_pkg::SUM_W:0] t;
    t = {1'b0, s} + (pbd_pkg::SUM_W + 1)'(v);
    return t[pbd_pkg::SUM_W] ? pbd_pkg::SUM_MAX : t[pbd_pkg::SUM_W-1:0];
  endfunction

  always_comb begin
    a_m    = abund_a_i & AMASK;
    b_m    = abund_b_i & AMASK;
    nz_a   = |a_m;
    nz_b   = |b_m;
    min_ab = (a_m < b_m) ? a_m : b_m;

    acc_nxt = acc_r;
    if (nz_a) acc_nxt.rich_a = cnt_inc(acc_r.rich_a);
    if (nz_b) acc_nxt.rich_b = cnt_inc(acc_r.rich_b);
    if (nz_a && nz_b) begin
      acc_nxt.shared  = cnt_inc(acc_r.shared);
      acc_nxt.min_sum = sum_add(acc_r.min_sum, min_ab);
    end
    acc_nxt.tot_a = sum_add(acc_r.tot_a, a_m);
    acc_nxt.tot_b = sum_add(acc_r.tot_b, b_m);
  end

  // The updated statistics go out unregistered so the last item is included.
  assign acc_o = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (take_i) begin
      acc_r <= last_i ? '0 : acc_nxt;
    end
  end

endmodule

FILE: sv/pbd_divser.sv
// Bit-serial restoring divider giving the Q1.16 dissimilarity 1 - 2*num/den.
`timescale 1ns / 1ps

module pbd_divser #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [DEN_W-1:0]          den_i,
  output logic                      done_o,
  output logic [pbd_pkg::Q_W-1:0]   dissim_o
);

  logic [DEN_W:0]                 rem_r, rem_nxt, rem_sel;
  logic [DEN_W-1:0]               den_r;
  logic [pbd_pkg::QBITS-1:0]      q_r, q_clip;
  logic [pbd_pkg::STEP_W-1:0]     step_r;
  logic                           busy_r;
  logic                           ge;

  // One quotient bit per cycle, most significant (weight 2^17) first.
  // The numerator never exceeds the denominator, so the remainder stays below 2*den.
  always_comb begin
    ge      = rem_r >= {1'b0, den_r};
    rem_sel = ge ? rem_r - {1'b0, den_r} : rem_r;
    rem_nxt = {rem_sel[DEN_W-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + pbd_pkg::STEP_W'(1);
      if (step_r == pbd_pkg::STEP_W'(pbd_pkg::QBITS - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= (DEN_W + 1)'(num_i);
      den_r <= den_i;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[pbd_pkg::QBITS-2:0], ge};
    end
  end

  always_comb begin
    q_clip = (q_r > pbd_pkg::QBITS'(pbd_pkg::Q_ONE)) ? pbd_pkg::QBITS'(pbd_pkg::Q_ONE) : q_r;
    if (den_r == '0) begin
      dissim_o = '0;
    end else begin
      dissim_o = pbd_pkg::Q_ONE - q_clip[pbd_pkg::Q_W-1:0];
    end
  end

  assign done_o = !busy_r;

endmodule

FILE: sv/pairwise_beta_dissimilarity.sv
// Top level: Sorensen and Bray-Curtis dissimilarity of two communities.
// Species items are taken one per cycle, but a last-species item waits while the
// previous comparison is divided; accumulation of the next comparison runs meanwhile.
// The dividers start on the edge that accepts the last species item; the result is loaded
// into the output once every quotient bit (one per cycle) is done and the output is free.
// A last-species item is held off until the previous result has moved to the output.
// Synchronous active-low reset clears all accumulators and empties the output.
`timescale 1ns / 1ps

module pairwise_beta_dissimilarity #(
  parameter int ABUND_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pbd_pkg::ABUND_W-1:0]       in_abund_a,
  input  logic [pbd_pkg::ABUND_W-1:0]       in_abund_b,
  input  logic                              in_last_species,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pbd_pkg::CNT_W-1:0]         out_richness_a,
  output logic [pbd_pkg::CNT_W-1:0]         out_richness_b,
  output logic [pbd_pkg::CNT_W-1:0]         out_shared_species,
  output logic [pbd_pkg::CNT_W-1:0]         out_delta_richness,
  output logic [pbd_pkg::SUM_W-1:0]         out_total_a,
  output logic [pbd_pkg::SUM_W-1:0]         out_total_b,
  output logic [pbd_pkg::SUM_W-1:0]         out_delta_total,
  output logic [pbd_pkg::TOT_W-1:0]         out_sum_of_totals,
  output logic [pbd_pkg::SUM_W-1:0]         out_min_sum,
  output logic [pbd_pkg::Q_W-1:0]           out_sorensen_dissim,
  output logic [pbd_pkg::Q_W-1:0]           out_bray_curtis_dissim,
  output logic                              out_both_empty
);

  pbd_pkg::state_t state_r, state_nxt;
  pbd_pkg::acc_t   acc, snap_r;

  logic take, take_last, start, load;
  logic out_valid_r, out_valid_nxt;
  logic sor_done, bc_done;
  logic [pbd_pkg::Q_W-1:0]    sor_q, bc_q;
  logic [pbd_pkg::RSUM_W-1:0] rsum;
  logic [pbd_pkg::TOT_W-1:0]  tsum;

  logic [pbd_pkg::CNT_W-1:0]  rich_a_r, rich_b_r, shared_r, d_rich_r;
  logic [pbd_pkg::SUM_W-1:0]  tot_a_r, tot_b_r, d_tot_r, min_sum_r;
  logic [pbd_pkg::TOT_W-1:0]  sum_tot_r;
  logic [pbd_pkg::Q_W-1:0]    sor_r, bc_r;
  logic                       empty_r;

  assign in_ready  = (state_r == pbd_pkg::ST_IDLE) || !in_last_species;
  assign take      = in_valid && in_ready;
  assign take_last = take && in_last_species;

  pbd_accum #(
    .ABUND_BITS (ABUND_BITS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .take_i    (take),
    .last_i    (in_last_species),
    .abund_a_i (in_abund_a),
    .abund_b_i (in_abund_b),
    .acc_o     (acc)
  );

  assign rsum = pbd_pkg::RSUM_W'(acc.rich_a) + pbd_pkg::RSUM_W'(acc.rich_b);
  assign tsum = pbd_pkg::TOT_W'(acc.tot_a) + pbd_pkg::TOT_W'(acc.tot_b);

  pbd_divser #(
    .NUM_W (pbd_pkg::CNT_W),
    .DEN_W (pbd_pkg::RSUM_W)
  ) u_div_sor (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .num_i    (acc.shared),
    .den_i    (rsum),
    .done_o   (sor_done),
    .dissim_o (sor_q)
  );

  pbd_divser #(
    .NUM_W (pbd_pkg::SUM_W),
    .DEN_W (pbd_pkg::TOT_W)
  ) u_div_bc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .num_i    (acc.min_sum),
    .den_i    (tsum),
    .done_o   (bc_done),
    .dissim_o (bc_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    start         = 1'b0;
    load          = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      pbd_pkg::ST_IDLE: begin
        if (take_last) begin
          start     = 1'b1;
          state_nxt = pbd_pkg::ST_DIV;
        end
      end
      pbd_pkg::ST_DIV: begin
        // The result moves out once both dividers are done and the output register is free.
        if (sor_done && bc_done && (!out_valid_r || out_ready)) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take_last) snap_r <= acc;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rich_a_r  <= snap_r.rich_a;
      rich_b_r  <= snap_r.rich_b;
      shared_r  <= snap_r.shared;
      d_rich_r  <= (snap_r.rich_a > snap_r.rich_b) ? snap_r.rich_a - snap_r.rich_b
                                                   : snap_r.rich_b - snap_r.rich_a;
      tot_a_r   <= snap_r.tot_a;
      tot_b_r   <= snap_r.tot_b;
      d_tot_r   <= (snap_r.tot_a > snap_r.tot_b) ? snap_r.tot_a - snap_r.tot_b
                                                 : snap_r.tot_b - snap_r.tot_a;
      sum_tot_r <= pbd_pkg::TOT_W'(snap_r.tot_a) + pbd_pkg::TOT_W'(snap_r.tot_b);
      min_sum_r <= snap_r.min_sum;
      sor_r     <= sor_q;
      bc_r      <= bc_q;
      empty_r   <= (snap_r.rich_a == '0) && (snap_r.rich_b == '0);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_richness_a         = rich_a_r;
  assign out_richness_b         = rich_b_r;
  assign out_shared_species     = shared_r;
  assign out_delta_richness     = d_rich_r;
  assign out_total_a            = tot_a_r;
  assign out_total_b            = tot_b_r;
  assign out_delta_total        = d_tot_r;
  assign out_sum_of_totals      = sum_tot_r;
  assign out_min_sum            = min_sum_r;
  assign out_sorensen_dissim    = sor_r;
  assign out_bray_curtis_dissim = bc_r;
  assign out_both_empty         = empty_r;

  a_ready_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_last_species && state_r == pbd_pkg::ST_DIV)
    else $error("input stalled on an item that is not the last species");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    sor_done == bc_done)
    else $error("the two dividers are out of step");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_both_empty |->
      out_sorensen_dissim == '0 && out_bray_curtis_dissim == '0)
    else $error("empty communities must report zero dissimilarity");

  a_shared_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_shared_species <= out_richness_a &&
                  out_shared_species <= out_richness_b &&
                  out_sorensen_dissim <= pbd_pkg::Q_ONE)
    else $error("shared count or dissimilarity out of range");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for pairwise_beta_dissimilarity: directed table, then random.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 60;
  localparam int N_PLAN       = 19;

  typedef struct packed {
    logic [pbd_pkg::CNT_W-1:0] richness_a;
    logic [pbd_pkg::CNT_W-1:0] richness_b;
    logic [pbd_pkg::CNT_W-1:0] shared_species;
    logic [pbd_pkg::CNT_W-1:0] delta_richness;
    logic [pbd_pkg::SUM_W-1:0] total_a;
    logic [pbd_pkg::SUM_W-1:0] total_b;
    logic [pbd_pkg::SUM_W-1:0] delta_total;
    logic [pbd_pkg::TOT_W-1:0] sum_of_totals;
    logic [pbd_pkg::SUM_W-1:0] min_sum;
    logic [pbd_pkg::Q_W-1:0]   sorensen_dissim;
    logic [pbd_pkg::Q_W-1:0]   bray_curtis_dissim;
    logic                      both_empty;
  } comparison_t;

  // One row sends the same species item reps times.
  typedef struct {
    logic [pbd_pkg::ABUND_W-1:0] abund_a;
    logic [pbd_pkg::ABUND_W-1:0] abund_b;
    logic                        last_sp;
    int                          reps;
    bit                          typed;
    comparison_t                 want;
  } species_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_LONG_STALL,
    RX_SPARSE
  } rx_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [pbd_pkg::ABUND_W-1:0] in_abund_a = '0;
  logic [pbd_pkg::ABUND_W-1:0] in_abund_b = '0;
  logic                        in_last_species = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [pbd_pkg::CNT_W-1:0]   out_richness_a;
  logic [pbd_pkg::CNT_W-1:0]   out_richness_b;
  logic [pbd_pkg::CNT_W-1:0]   out_shared_species;
  logic [pbd_pkg::CNT_W-1:0]   out_delta_richness;
  logic [pbd_pkg::SUM_W-1:0]   out_total_a;
  logic [pbd_pkg::SUM_W-1:0]   out_total_b;
  logic [pbd_pkg::SUM_W-1:0]   out_delta_total;
  logic [pbd_pkg::TOT_W-1:0]   out_sum_of_totals;
  logic [pbd_pkg::SUM_W-1:0]   out_min_sum;
  logic [pbd_pkg::Q_W-1:0]     out_sorensen_dissim;
  logic [pbd_pkg::Q_W-1:0]     out_bray_curtis_dissim;
  logic                        out_both_empty;

  // Running statistics of the comparison in progress.
  logic [pbd_pkg::CNT_W-1:0]   seen_a = '0;
  logic [pbd_pkg::CNT_W-1:0]   seen_b = '0;
  logic [pbd_pkg::CNT_W-1:0]   seen_both = '0;
  logic [pbd_pkg::SUM_W-1:0]   min_acc = '0;
  logic [pbd_pkg::SUM_W-1:0]   tot_a_acc = '0;
  logic [pbd_pkg::SUM_W-1:0]   tot_b_acc = '0;

  comparison_t        pending_comparisons [$];
  int                 mismatches = 0;
  int                 results_seen = 0;
  int                 cycles = 0;
  int                 burst_left = 0;
  int                 stall_tick = 0;
  rx_mode_t           stall_mode = RX_OPEN;

  species_row_t plan [N_PLAN] = '{
    // Both communities empty right after reset.
    '{16'h0000, 16'h0000, 1'b1, 1, 1'b1,
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1}},
    '{16'hFFFF, 16'h0000, 1'b1, 1, 1'b1,
      '{1, 0, 0, 1, 65535, 0, 65535, 65535, 0, 65536, 65536, 0}},
    '{16'h0000, 16'hFFFF, 1'b1, 1, 1'b1,
      '{0, 1, 0, 1, 0, 65535, 65535, 65535, 0, 65536, 65536, 0}},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1, 1'b1,
      '{1, 1, 1, 0, 65535, 65535, 0, 131070, 65535, 0, 0, 0}},
    '{16'h0001, 16'hFFFF, 1'b1, 1, 1'b0, '0},
    '{16'h8000, 16'h7FFF, 1'b0, 1, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 1'b0, 1, 1'b0, '0},
    '{16'h0000, 16'h0003, 1'b0, 1, 1'b0, '0},
    '{16'h0007, 16'h0000, 1'b0, 1, 1'b0, '0},
    '{16'h0000, 16'h0000, 1'b1, 1, 1'b0, '0},
    '{16'h0000, 16'h0000, 1'b0, 3, 1'b0, '0},
    '{16'h0000, 16'h0000, 1'b1, 1, 1'b1,
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1}},
    // Counts and sums both saturate.
    '{16'hFFFF, 16'hFFFF, 1'b0, 258, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1, 1'b1,
      '{255, 255, 255, 0, 8388607, 8388607, 0, 16777214, 8388607, 0, 0, 0}},
    // Counts saturate while the sums stay small.
    '{16'h0001, 16'h0002, 1'b0, 258, 1'b0, '0},
    '{16'h0000, 16'h0001, 1'b1, 1, 1'b0, '0},
    // Only the total of community A saturates.
    '{16'hFFFF, 16'h0000, 1'b0, 130, 1'b0, '0},
    '{16'h0000, 16'h0001, 1'b1, 1, 1'b0, '0},
    // Single-species comparisons back to back run into the divider hold-off.
    '{16'h0010, 16'h0020, 1'b1, 4, 1'b0, '0}
  };

  pairwise_beta_dissimilarity DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_abund_a             (in_abund_a),
    .in_abund_b             (in_abund_b),
    .in_last_species        (in_last_species),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_richness_a         (out_richness_a),
    .out_richness_b         (out_richness_b),
    .out_shared_species     (out_shared_species),
    .out_delta_richness     (out_delta_richness),
    .out_total_a            (out_total_a),
    .out_total_b            (out_total_b),
    .out_delta_total        (out_delta_total),
    .out_sum_of_totals      (out_sum_of_totals),
    .out_min_sum            (out_min_sum),
    .out_sorensen_dissim    (out_sorensen_dissim),
    .out_bray_curtis_dissim (out_bray_curtis_dissim),
    .out_both_empty         (out_both_empty)
  );

  always #2 clk = ~clk;

  function automatic logic [pbd_pkg::CNT_W-1:0] count_up(
    input logic [pbd_pkg::CNT_W-1:0] c
  );
    return (c == pbd_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [pbd_pkg::SUM_W-1:0] sum_up(
    input logic [pbd_pkg::SUM_W-1:0]   s,
    input logic [pbd_pkg::ABUND_W-1:0] v
  );
    logic [pbd_pkg::SUM_W:0] t;
    t = s + v;
    return (t > pbd_pkg::SUM_MAX) ? pbd_pkg::SUM_MAX : t[pbd_pkg::SUM_W-1:0];
  endfunction

  // 1.0 minus twice the ratio, in Q1.16, floored and clipped at zero.
  function automatic logic [pbd_pkg::Q_W-1:0] q16_dissim(input longint unsigned num,
                                                          input longint unsigned den);
    longint unsigned q;
    if (den == 0) return '0;
    q = (num << 17) / den;
    if (q > pbd_pkg::Q_ONE) q = pbd_pkg::Q_ONE;
    return pbd_pkg::Q_ONE - q[pbd_pkg::Q_W-1:0];
  endfunction

  function automatic bit tally_species(input logic [pbd_pkg::ABUND_W-1:0] a,
                                       input logic [pbd_pkg::ABUND_W-1:0] b,
                                       input logic last,
                                       output comparison_t r);
    if (a != 0) seen_a = count_up(seen_a);
    if (b != 0) seen_b = count_up(seen_b);
    if (a != 0 && b != 0) begin
      seen_both = count_up(seen_both);
      min_acc = sum_up(min_acc, (a < b) ? a : b);
    end
    tot_a_acc = sum_up(tot_a_acc, a);
    tot_b_acc = sum_up(tot_b_acc, b);
    if (!last) return 1'b0;
    r.richness_a         = seen_a;
    r.richness_b         = seen_b;
    r.shared_species     = seen_both;
    r.delta_richness     = (seen_a > seen_b) ? seen_a - seen_b : seen_b - seen_a;
    r.total_a            = tot_a_acc;
    r.total_b            = tot_b_acc;
    r.delta_total        = (tot_a_acc > tot_b_acc) ? tot_a_acc - tot_b_acc
                                                   : tot_b_acc - tot_a_acc;
    r.sum_of_totals      = tot_a_acc + tot_b_acc;
    r.min_sum            = min_acc;
    r.sorensen_dissim    = q16_dissim(seen_both, seen_a + seen_b);
    r.bray_curtis_dissim = q16_dissim(min_acc, tot_a_acc + tot_b_acc);
    r.both_empty         = (seen_a == 0 && seen_b == 0);
    seen_a    = '0;
    seen_b    = '0;
    seen_both = '0;
    min_acc   = '0;
    tot_a_acc = '0;
    tot_b_acc = '0;
    return 1'b1;
  endfunction

  function automatic logic [pbd_pkg::ABUND_W-1:0] rand_abund();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return '0;
    if (pick == 3) return '1;
    if (pick < 6) return pbd_pkg::ABUND_W'($urandom_range(1, 15));
    return pbd_pkg::ABUND_W'($urandom());
  endfunction

  // Called at a falling edge; may insert an idle gap when the current burst is used up.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic send_species(input logic [pbd_pkg::ABUND_W-1:0] a,
                              input logic [pbd_pkg::ABUND_W-1:0] b,
                              input logic last, input bit typed, input comparison_t want);
    comparison_t predicted;
    pace_sender();
    in_valid        = 1'b1;
    in_abund_a      = a;
    in_abund_b      = b;
    in_last_species = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tally_species(a, b, last, predicted))
      pending_comparisons.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic flag_mismatch(input string what, input longint want_v, input longint got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in result %0d, %s: expected %0d, got %0d",
               results_seen, what, want_v, got_v);
  endtask

  task automatic compare_result(input comparison_t w, input comparison_t g);
    if (w.richness_a !== g.richness_a)
      flag_mismatch("richness_a", w.richness_a, g.richness_a);
    if (w.richness_b !== g.richness_b)
      flag_mismatch("richness_b", w.richness_b, g.richness_b);
    if (w.shared_species !== g.shared_species)
      flag_mismatch("shared_species", w.shared_species, g.shared_species);
    if (w.delta_richness !== g.delta_richness)
      flag_mismatch("delta_richness", w.delta_richness, g.delta_richness);
    if (w.total_a !== g.total_a)
      flag_mismatch("total_a", w.total_a, g.total_a);
    if (w.total_b !== g.total_b)
      flag_mismatch("total_b", w.total_b, g.total_b);
    if (w.delta_total !== g.delta_total)
      flag_mismatch("delta_total", w.delta_total, g.delta_total);
    if (w.sum_of_totals !== g.sum_of_totals)
      flag_mismatch("sum_of_totals", w.sum_of_totals, g.sum_of_totals);
    if (w.min_sum !== g.min_sum)
      flag_mismatch("min_sum", w.min_sum, g.min_sum);
    if (w.sorensen_dissim !== g.sorensen_dissim)
      flag_mismatch("sorensen_dissim", w.sorensen_dissim, g.sorensen_dissim);
    if (w.bray_curtis_dissim !== g.bray_curtis_dissim)
      flag_mismatch("bray_curtis_dissim", w.bray_curtis_dissim, g.bray_curtis_dissim);
    if (w.both_empty !== g.both_empty)
      flag_mismatch("both_empty", w.both_empty, g.both_empty);
  endtask

  always @(posedge clk) begin
    comparison_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_richness_a, out_richness_b, out_shared_species, out_delta_richness,
              out_total_a, out_total_b, out_delta_total, out_sum_of_totals,
              out_min_sum, out_sorensen_dissim, out_bray_curtis_dissim, out_both_empty};
      if (pending_comparisons.size() == 0)
        flag_mismatch("result with nothing pending, sorensen_dissim", 0,
                      out_sorensen_dissim);
      else
        compare_result(pending_comparisons.pop_front(), got);
      results_seen++;
    end
  end

  // The receiver picks a new random stall pattern each time stall_tick wraps to zero.
  always @(negedge clk) begin
    if (stall_tick == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    stall_tick <= (stall_tick == 96) ? 0 : stall_tick + 1;
    case (stall_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      RX_LONG_STALL: begin
        out_ready <= (stall_tick % 30) >= 25;
      end
      default: begin
        out_ready <= (stall_tick % 3) == 0;
      end
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int n_species;
    int sent;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      repeat (plan[i].reps)
        send_species(plan[i].abund_a, plan[i].abund_b, plan[i].last_sp,
                     plan[i].typed, plan[i].want);
    end

    // Mostly short comparisons, some near the nominal size, a few long ones that can reach saturation.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n_species = $urandom_range(0, 99);
      if (n_species < 80)
        n_species = $urandom_range(1, 24);
      else if (n_species < 97)
        n_species = $urandom_range(25, 128);
      else
        n_species = $urandom_range(129, 320);
      for (int k = 1; k <= n_species; k++)
        send_species(rand_abund(), rand_abund(), k == n_species, 1'b0, '0);
      sent += n_species;
    end
    in_valid = 1'b0;

    while (pending_comparisons.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
